// ===== rtl/core/speck_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128/256 package
// Shared constants, register codes and word types of the Speck cipher core.
// ----------------------------------------------------------------------------
package speck_pkg;

    localparam int ROUND_COUNT = 34;
    localparam int RND_W       = $clog2(ROUND_COUNT);
    localparam int WORD_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

    localparam logic [REG_IDX_W-1:0] REG_KEY0       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY1       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY2       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY3       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd6;

    localparam logic [1:0] MODE_ENC = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_CTR = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RND_W-1:0]  rnd_t;

    typedef struct packed {
        word_t block_low;
        word_t block_high;
        logic  last_block;
    } in_word_t;

    typedef struct packed {
        word_t result_low;
        word_t result_high;
    } out_word_t;

    typedef struct packed {
        word_t      key0;
        word_t      key1;
        word_t      key2;
        word_t      key3;
        logic [1:0] mode;
        word_t      ctr_high;
        word_t      ctr_low;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic reload;
    } ctr_cmd_t;

endpackage

// ===== rtl/core/speck128_256_cipher_ctr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck128/256 cipher with block and CTR modes
// Top level: APB register port, word input and result output channels.
// ----------------------------------------------------------------------------
// One shared round unit does one Speck round per clock. In encrypt and CTR mode
// the round keys are expanded alongside the rounds. In decrypt mode the keys
// are first expanded into a 34-entry key store, one per cycle, and then read
// back in reverse order. The core takes no new word until the last one is
// done. The result sits in an output register, so the next word is taken
// while it waits. Registers are 64 bits wide at byte addresses 8 apart and
// should be written only while idle.
module speck128_256_cipher_ctr (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [speck_pkg::ADDR_W-1:0] paddr,
    input  speck_pkg::word_t             pwdata,
    output speck_pkg::word_t             prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  speck_pkg::in_word_t          in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output speck_pkg::out_word_t         out_data
);
    import speck_pkg::*;

    cfg_t     cfg;
    ctr_cmd_t ctr_cmd;

    speck_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctr_cmd (ctr_cmd),
        .cfg     (cfg)
    );

    speck_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg       (cfg),
        .ctr_cmd   (ctr_cmd)
    );

endmodule

// ===== rtl/core/speck_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck round unit
// One encryption round, one decryption round and one key schedule step.
// ----------------------------------------------------------------------------
module speck_round (
    input  speck_pkg::word_t x,
    input  speck_pkg::word_t y,
    input  speck_pkg::word_t enc_key,
    input  speck_pkg::word_t dec_key,
    input  speck_pkg::word_t lane,
    input  speck_pkg::rnd_t  idx,
    output speck_pkg::word_t enc_x,
    output speck_pkg::word_t enc_y,
    output speck_pkg::word_t dec_x,
    output speck_pkg::word_t dec_y,
    output speck_pkg::word_t key_next,
    output speck_pkg::word_t lane_next
);
    import speck_pkg::*;

    word_t enc_sum;
    word_t dec_mix;
    word_t dec_diff;

    assign enc_sum = {x[7:0], x[63:8]} + y;
    assign enc_x   = enc_sum ^ enc_key;
    assign enc_y   = {y[60:0], y[63:61]} ^ enc_x;

    assign dec_mix  = x ^ y;
    assign dec_y    = {dec_mix[2:0], dec_mix[63:3]};
    assign dec_diff = (x ^ dec_key) - dec_y;
    assign dec_x    = {dec_diff[55:0], dec_diff[63:56]};

    assign lane_next = (enc_key + {lane[7:0], lane[63:8]}) ^ {{(WORD_W-RND_W){1'b0}}, idx};
    assign key_next  = {enc_key[60:0], enc_key[63:61]} ^ lane_next;

endmodule

// ===== rtl/core/speck_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck configuration registers
// Register file on the APB port, and the 128-bit CTR counter.
// ----------------------------------------------------------------------------
module speck_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [speck_pkg::ADDR_W-1:0]     paddr,
    input  speck_pkg::word_t                 pwdata,
    output speck_pkg::word_t                 prdata,
    output logic                             pready,
    input  speck_pkg::ctr_cmd_t              ctr_cmd,
    output speck_pkg::cfg_t                  cfg
);
    import speck_pkg::*;

    word_t                key0_reg, key0_next;
    word_t                key1_reg, key1_next;
    word_t                key2_reg, key2_next;
    word_t                key3_reg, key3_next;
    word_t                nonce_low_reg, nonce_low_next;
    word_t                nonce_high_reg, nonce_high_next;
    logic [1:0]           mode_reg, mode_next;
    logic [2*WORD_W-1:0]  ctr_reg, ctr_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_comb
    begin
        key0_next       = key0_reg;
        key1_next       = key1_reg;
        key2_next       = key2_reg;
        key3_next       = key3_reg;
        nonce_low_next  = nonce_low_reg;
        nonce_high_next = nonce_high_reg;
        mode_next       = mode_reg;
        ctr_next        = ctr_reg;
        if (ctr_cmd.advance)
        begin
            ctr_next = ctr_reg + (2*WORD_W)'(1);
        end
        if (ctr_cmd.reload)
        begin
            ctr_next = {nonce_high_reg, nonce_low_reg};
        end
        if (wr_en)
        begin
            case (reg_idx)
                REG_KEY0:       key0_next = pwdata;
                REG_KEY1:       key1_next = pwdata;
                REG_KEY2:       key2_next = pwdata;
                REG_KEY3:       key3_next = pwdata;
                REG_NONCE_LOW:
                begin
                    nonce_low_next = pwdata;
                    ctr_next       = {nonce_high_reg, pwdata};
                end
                REG_NONCE_HIGH:
                begin
                    nonce_high_next = pwdata;
                    ctr_next        = {pwdata, nonce_low_reg};
                end
                REG_MODE:       mode_next = pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            mode_reg       <= MODE_ENC;
            ctr_reg        <= '0;
        end
        else
        begin
            key0_reg       <= key0_next;
            key1_reg       <= key1_next;
            key2_reg       <= key2_next;
            key3_reg       <= key3_next;
            nonce_low_reg  <= nonce_low_next;
            nonce_high_reg <= nonce_high_next;
            mode_reg       <= mode_next;
            ctr_reg        <= ctr_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY0:       prdata = key0_reg;
            REG_KEY1:       prdata = key1_reg;
            REG_KEY2:       prdata = key2_reg;
            REG_KEY3:       prdata = key3_reg;
            REG_NONCE_LOW:  prdata = nonce_low_reg;
            REG_NONCE_HIGH: prdata = nonce_high_reg;
            REG_MODE:       prdata = {{(WORD_W-2){1'b0}}, mode_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.key0     = key0_reg;
    assign cfg.key1     = key1_reg;
    assign cfg.key2     = key2_reg;
    assign cfg.key3     = key3_reg;
    assign cfg.mode     = mode_reg;
    assign cfg.ctr_high = ctr_reg[2*WORD_W-1:WORD_W];
    assign cfg.ctr_low  = ctr_reg[WORD_W-1:0];

endmodule

// ===== rtl/core/speck_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speck round sequencer
// Drives the shared round unit, keeps the round key store and the output word.
// ----------------------------------------------------------------------------
module speck_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  speck_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output speck_pkg::out_word_t out_data,
    input  speck_pkg::cfg_t      cfg,
    output speck_pkg::ctr_cmd_t  ctr_cmd
);
    import speck_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_DEC    = 3'd3;
    localparam logic [2:0] ST_ENC    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    rnd_t                rnd_reg, rnd_next;
    logic                out_valid_reg, out_valid_next;
    logic                ctr_mode_reg, ctr_mode_next;
    word_t               x_reg, x_next;
    word_t               y_reg, y_next;
    word_t               k_reg, k_next;
    word_t               l0_reg, l0_next;
    word_t               l1_reg, l1_next;
    word_t               l2_reg, l2_next;
    logic [2*WORD_W-1:0] data_reg, data_next;
    out_word_t           out_reg, out_next;
    word_t               rk_q;
    word_t               key_mem [ROUND_COUNT];

    word_t               enc_x, enc_y, dec_x, dec_y, key_step, lane_step;
    logic                accept;
    logic                out_free;
    logic                mem_wr;
    logic                mem_rd;
    rnd_t                rd_addr;
    logic [2*WORD_W-1:0] result;

    speck_round u_round (
        .x         (x_reg),
        .y         (y_reg),
        .enc_key   (k_reg),
        .dec_key   (rk_q),
        .lane      (l0_reg),
        .idx       (rnd_reg),
        .enc_x     (enc_x),
        .enc_y     (enc_y),
        .dec_x     (dec_x),
        .dec_y     (dec_y),
        .key_next  (key_step),
        .lane_next (lane_step)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign ctr_cmd.advance = accept && (cfg.mode == MODE_CTR);
    assign ctr_cmd.reload  = accept && (cfg.mode == MODE_CTR) && in_data.last_block;

    assign mem_wr  = (state_reg == ST_EXPAND);
    assign mem_rd  = (state_reg == ST_PRIME) || ((state_reg == ST_DEC) && (rnd_reg != '0));
    assign rd_addr = (state_reg == ST_PRIME) ? LAST_ROUND : rnd_reg - RND_W'(1);
    assign result  = ctr_mode_reg ? (data_reg ^ {x_reg, y_reg}) : {x_reg, y_reg};

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg;
        ctr_mode_next  = ctr_mode_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        l0_next        = l0_reg;
        l1_next        = l1_reg;
        l2_next        = l2_reg;
        data_next      = data_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctr_mode_next = (cfg.mode == MODE_CTR);
                    data_next     = {in_data.block_high, in_data.block_low};
                    if (cfg.mode == MODE_CTR)
                    begin
                        x_next = cfg.ctr_high;
                        y_next = cfg.ctr_low;
                    end
                    else
                    begin
                        x_next = in_data.block_high;
                        y_next = in_data.block_low;
                    end
                    k_next     = cfg.key0;
                    l0_next    = cfg.key1;
                    l1_next    = cfg.key2;
                    l2_next    = cfg.key3;
                    rnd_next   = '0;
                    state_next = (cfg.mode == MODE_DEC) ? ST_EXPAND : ST_ENC;
                end
            end
            ST_EXPAND:
            begin
                k_next  = key_step;
                l0_next = l1_reg;
                l1_next = l2_reg;
                l2_next = lane_step;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    rnd_next = rnd_reg + RND_W'(1);
                end
            end
            ST_PRIME:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                x_next = dec_x;
                y_next = dec_y;
                if (rnd_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rnd_next = rnd_reg - RND_W'(1);
                end
            end
            ST_ENC:
            begin
                x_next  = enc_x;
                y_next  = enc_y;
                k_next  = key_step;
                l0_next = l1_reg;
                l1_next = l2_reg;
                l2_next = lane_step;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rnd_next = rnd_reg + RND_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.result_high = result[2*WORD_W-1:WORD_W];
                    out_next.result_low  = result[WORD_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            ctr_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
            ctr_mode_reg  <= ctr_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        l0_reg   <= l0_next;
        l1_reg   <= l1_next;
        l2_reg   <= l2_next;
        data_reg <= data_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            key_mem[rnd_reg] <= k_reg;
        end
        if (mem_rd)
        begin
            rk_q <= key_mem[rd_addr];
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("engine still ready after taking a word");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !out_free |=> (state_reg == ST_DONE) && out_valid_reg)
        else $error("finished word lost while the output was full");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENC) || (state_reg == ST_DEC) || (state_reg == ST_EXPAND)
        |-> rnd_reg <= LAST_ROUND)
        else $error("round index out of range");

    a_prime_from_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRIME) |-> $past(state_reg) == ST_EXPAND
        && $past(rnd_reg) == LAST_ROUND)
        else $error("key store read before it was filled");

    a_ctr_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ctr_cmd.reload |-> ctr_cmd.advance && accept)
        else $error("counter reload outside a CTR word");

endmodule
